// ===== src/lis_pkg.sv =====
// Package for the patience-sort LIS stream: defaults and the control word passed along the cells.
`timescale 1ns / 1ps

package lis_pkg;

  localparam int unsigned MAX_TAILS_DEF  = 1024;
  localparam int unsigned VALUE_BITS_DEF = 32;

  // Control word that travels with each value down the chain.
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
    logic placed;
    logic appended;
  } ctl_t;

endpackage

// ===== src/lis_cell.sv =====
// One tail cell: holds a single tail and forwards the passing value to its neighbour.
`timescale 1ns / 1ps

module lis_cell #(
  parameter int unsigned ValueBits = lis_pkg::VALUE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  lis_pkg::ctl_t          ctl_i,
  input  logic [ValueBits-1:0]   key_i,
  output lis_pkg::ctl_t          ctl_o,
  output logic [ValueBits-1:0]   key_o
);

  logic                 full_q, full_d;
  logic [ValueBits-1:0] tail_q;
  logic [ValueBits-1:0] key_q;
  lis_pkg::ctl_t        ctl_q, ctl_d;
  logic                 own_valid;
  logic                 take;

  // A first item sweeps the store empty as it passes.
  assign own_valid = full_q && !ctl_i.first;
  assign take      = ctl_i.valid && !ctl_i.placed &&
                     (!own_valid || !($signed(tail_q) < $signed(key_i)));

  always_comb begin
    ctl_d          = ctl_i;
    ctl_d.placed   = ctl_i.placed | take;
    ctl_d.appended = ctl_i.appended | (take && !own_valid);
    full_d         = full_q;
    if (ctl_i.valid) begin
      full_d = take | own_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
      ctl_q  <= '0;
    end else if (en_i) begin
      full_q <= full_d;
      ctl_q  <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      key_q <= key_i;
      if (take) begin
        tail_q <= key_i;
      end
    end
  end

  assign ctl_o = ctl_q;
  assign key_o = key_q;

endmodule

// ===== src/lis_tally.sv =====
// End of chain: keeps tail count and overflow flag and holds the result register.
`timescale 1ns / 1ps

module lis_tally #(
  parameter int unsigned LenBits = 11
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  lis_pkg::ctl_t      ctl_i,
  output logic               out_valid_o,
  output logic [LenBits-1:0] lis_length_o,
  output logic               overflow_o,
  output logic               is_final_o
);

  logic               valid_q;
  logic [LenBits-1:0] cnt_q, cnt_d;
  logic               ov_q, ov_d;
  logic               final_q;

  always_comb begin
    cnt_d = (ctl_i.first ? '0 : cnt_q) + LenBits'(ctl_i.appended);
    ov_d  = (ctl_i.first ? 1'b0 : ov_q) | !ctl_i.placed;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
      final_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= ctl_i.valid;
      if (ctl_i.valid) begin
        cnt_q   <= cnt_d;
        ov_q    <= ov_d;
        final_q <= ctl_i.last;
      end
    end
  end

  assign out_valid_o  = valid_q;
  assign lis_length_o = cnt_q;
  assign overflow_o   = ov_q;
  assign is_final_o   = final_q;

endmodule

// ===== src/lis_length_patience_stream.sv =====
// Top level: systolic chain of tail cells computing the running LIS length.
//
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i / in_stall_o | value_i, first_item_i, last_item_i
//  out     | output    | out_valid_o/out_stall_i | lis_length_o, overflow_o, is_final_o
//
// One value enters per cycle while the input is not stalled. The first cell loads
// at the transfer edge, then MaxTails - 1 further cells and the tally register
// follow in order before the result is offered; a stall holds every register.
// Reset empties all cells and clears the count and overflow flag at once.
// A stalled result freezes the whole chain, so input is stalled in the same cycle.
`timescale 1ns / 1ps

module lis_length_patience_stream #(
  parameter int unsigned MaxTails  = lis_pkg::MAX_TAILS_DEF,
  parameter int unsigned ValueBits = lis_pkg::VALUE_BITS_DEF,
  parameter int unsigned LenBits   = $clog2(MaxTails + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [ValueBits-1:0] value_i,
  input  logic                 first_item_i,
  input  logic                 last_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [LenBits-1:0]   lis_length_o,
  output logic                 overflow_o,
  output logic                 is_final_o
);

  logic                 en;
  lis_pkg::ctl_t        ctl [0:MaxTails];
  logic [ValueBits-1:0] key [0:MaxTails-1];

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  assign ctl[0] = '{valid: in_valid_i, first: first_item_i, last: last_item_i,
                    placed: 1'b0, appended: 1'b0};
  assign key[0] = value_i;

  for (genvar k = 0; k < MaxTails; k++) begin : g_cell
    if (k < MaxTails - 1) begin : g_mid
      lis_cell #(.ValueBits(ValueBits)) u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .en_i   (en),
        .ctl_i  (ctl[k]),
        .key_i  (key[k]),
        .ctl_o  (ctl[k+1]),
        .key_o  (key[k+1])
      );
    end else begin : g_end
      lis_cell #(.ValueBits(ValueBits)) u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .en_i   (en),
        .ctl_i  (ctl[k]),
        .key_i  (key[k]),
        .ctl_o  (ctl[k+1]),
        .key_o  ()
      );
    end
  end

  lis_tally #(.LenBits(LenBits)) u_tally (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .ctl_i        (ctl[MaxTails]),
    .out_valid_o  (out_valid_o),
    .lis_length_o (lis_length_o),
    .overflow_o   (overflow_o),
    .is_final_o   (is_final_o)
  );

endmodule

// ===== src/lis_checker.sv =====
// Port-level checks for the LIS stream, bound to the top level.
`timescale 1ns / 1ps

module lis_checker #(
  parameter int unsigned MaxTails = lis_pkg::MAX_TAILS_DEF,
  parameter int unsigned LenBits  = $clog2(MaxTails + 1)
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [LenBits-1:0] lis_length_o,
  input logic               overflow_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(lis_length_o))
    else $error("stalled result not held");

  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> lis_length_o != '0 && lis_length_o <= LenBits'(MaxTails))
    else $error("length out of range");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_o |-> lis_length_o == LenBits'(MaxTails))
    else $error("overflow without full store");

  a_stall_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output stall");

endmodule

bind lis_length_patience_stream lis_checker #(
  .MaxTails (MaxTails),
  .LenBits  (LenBits)
) u_lis_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .lis_length_o (lis_length_o),
  .overflow_o   (overflow_o)
);
